>>> rtl/core/cpualu_pkg.sv
`default_nettype none

package cpualu_pkg;

    typedef enum logic [4:0] {
        OP_ADD     = 5'd0,
        OP_ADC     = 5'd1,
        OP_SUB     = 5'd2,
        OP_SBC     = 5'd3,
        OP_AND     = 5'd4,
        OP_XOR     = 5'd5,
        OP_OR      = 5'd6,
        OP_CP      = 5'd7,
        OP_INC8    = 5'd8,
        OP_DEC8    = 5'd9,
        OP_DAA     = 5'd10,
        OP_CPL     = 5'd11,
        OP_SCF     = 5'd12,
        OP_CCF     = 5'd13,
        OP_RLCA    = 5'd14,
        OP_RRCA    = 5'd15,
        OP_RLA     = 5'd16,
        OP_RRA     = 5'd17,
        OP_PREFIX  = 5'd18,
        OP_ADD16   = 5'd19,
        OP_ADD_SP  = 5'd20,
        OP_INC16   = 5'd21,
        OP_DEC16   = 5'd22
    } op_t;

    // Groups of the prefixed opcode, bits 7-6.
    typedef enum logic [1:0] {
        GRP_SHIFT = 2'd0,
        GRP_BIT   = 2'd1,
        GRP_RES   = 2'd2,
        GRP_SET   = 2'd3
    } pgrp_t;

    // Shift kinds of the prefixed opcode, bits 5-3.
    typedef enum logic [2:0] {
        SH_RLC  = 3'd0,
        SH_RRC  = 3'd1,
        SH_RL   = 3'd2,
        SH_RR   = 3'd3,
        SH_SLA  = 3'd4,
        SH_SRA  = 3'd5,
        SH_SWAP = 3'd6,
        SH_SRL  = 3'd7
    } shift_t;

    // Flag bit positions.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [3:0] DAA_NIB_MAX  = 4'h9;
    localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
    localparam logic [7:0] DAA_ADJ_HI   = 8'h60;

    localparam int unsigned IN_BITS  = 49;
    localparam int unsigned IN_BYTES = 7;
    localparam int unsigned OUT_BITS = 21;
    localparam int unsigned OUT_BYTES = 3;

endpackage

`default_nettype wire

>>> rtl/core/cpu_alu_with_flags.sv
// Eight-bit processor ALU with Z, N, H and C flags.
// Input channel s_axis_*: one item carries the operation, two 16-bit operands,
// the prefixed opcode byte and the incoming flags, packed in s_axis_tdata.
// Output channel m_axis_*: one result item per input item, carrying the
// result, the new flags and the write-back bit, packed in m_axis_tdata.
// Items are accepted when tvalid and tready are both high at a rising edge.
// The item is first captured in an input register; the ALU logic between that
// register and the result register is a single pass, and the result item is
// presented once the result register has loaded it.
// Throughput is one item per cycle: a new item is accepted in every cycle in
// which the result register is empty or is being taken.
// When the receiver holds m_axis_tready low, the result register holds its
// item, the input register fills behind it, and then s_axis_tready drops.
// Nothing is lost or repeated across a stall.
// The asynchronous active-low reset empties both registers; no result item
// is presented until a new item has been accepted.
`default_nettype none

module cpu_alu_with_flags (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0 up: operation[4:0], operand_a[20:5], operand_b[36:21],
    // prefix_opcode[44:37], flags_in[48:45], zero fill[55:49].
    input  wire logic [cpualu_pkg::IN_BYTES*8-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0 up: result[15:0], flags_out[19:16], write_back[20],
    // zero fill[23:21].
    output logic [cpualu_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);

    logic                               in_valid_reg;
    logic [cpualu_pkg::IN_BITS-1:0]     in_data_reg;
    logic                               out_valid_reg;
    logic [cpualu_pkg::OUT_BITS-1:0]    out_data_reg;
    logic                               out_load;
    logic                               in_load;

    // Unpacked input fields.
    logic [4:0]  op_raw;
    logic [15:0] a16;
    logic [15:0] b16;
    logic [7:0]  pre;
    logic [3:0]  fin;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;

    // Arithmetic intermediates.
    logic        carry_t;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  daa_adj;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [15:0] sp_sum;
    logic [8:0]  sp_c9;
    logic [4:0]  sp_h5;
    logic [1:0]  pgrp;
    logic [2:0]  psel;
    logic [7:0]  pmask;
    logic [7:0]  sh_r;
    logic        sh_c;

    logic [15:0] res;
    logic [3:0]  fl;
    logic        wb;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_axis_tdata[cpualu_pkg::IN_BITS-1:0];
        end
        if (out_load)
        begin
            out_data_reg <= {wb, fl, res};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(cpualu_pkg::OUT_BYTES*8-cpualu_pkg::OUT_BITS){1'b0}},
                            out_data_reg};

    assign op_raw = in_data_reg[4:0];
    assign a16    = in_data_reg[20:5];
    assign b16    = in_data_reg[36:21];
    assign pre    = in_data_reg[44:37];
    assign fin    = in_data_reg[48:45];
    assign a      = a16[7:0];
    assign b      = b16[7:0];
    assign cin    = fin[cpualu_pkg::FLAG_C];

    always_comb
    begin
        carry_t = ((cpualu_pkg::op_t'(op_raw) == cpualu_pkg::OP_ADC) ||
                   (cpualu_pkg::op_t'(op_raw) == cpualu_pkg::OP_SBC)) ? cin : 1'b0;

        sum9   = {1'b0, a} + {1'b0, b} + {8'd0, carry_t};
        hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
        // Borrow out of the top bit gives the C and H flags of subtraction.
        diff9  = {1'b0, a} - {1'b0, b} - {8'd0, carry_t};
        hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_t};
        inc8   = a + 8'd1;
        dec8   = a - 8'd1;

        // Decimal adjust after an add or a subtract.
        daa_adj = 8'd0;
        daa_c   = 1'b0;
        if (fin[cpualu_pkg::FLAG_H] ||
            (!fin[cpualu_pkg::FLAG_N] && (a[3:0] > cpualu_pkg::DAA_NIB_MAX)))
        begin
            daa_adj = cpualu_pkg::DAA_ADJ_LO;
        end
        if (cin || (!fin[cpualu_pkg::FLAG_N] && (a > cpualu_pkg::DAA_LIMIT)))
        begin
            daa_adj = daa_adj | cpualu_pkg::DAA_ADJ_HI;
            daa_c   = 1'b1;
        end
        daa_r = fin[cpualu_pkg::FLAG_N] ? (a - daa_adj) : (a + daa_adj);

        sum17  = {1'b0, a16} + {1'b0, b16};
        hsum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        sp_sum = a16 + {{8{b[7]}}, b};
        sp_c9  = {1'b0, a} + {1'b0, b};
        sp_h5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};

        pgrp  = pre[7:6];
        psel  = pre[5:3];
        pmask = 8'd1 << psel;

        unique case (cpualu_pkg::shift_t'(psel))
            cpualu_pkg::SH_RLC:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], a[7]};
            end
            cpualu_pkg::SH_RRC:
            begin
                sh_c = a[0];
                sh_r = {a[0], a[7:1]};
            end
            cpualu_pkg::SH_RL:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], cin};
            end
            cpualu_pkg::SH_RR:
            begin
                sh_c = a[0];
                sh_r = {cin, a[7:1]};
            end
            cpualu_pkg::SH_SLA:
            begin
                sh_c = a[7];
                sh_r = {a[6:0], 1'b0};
            end
            cpualu_pkg::SH_SRA:
            begin
                sh_c = a[0];
                sh_r = {a[7], a[7:1]};
            end
            cpualu_pkg::SH_SWAP:
            begin
                sh_c = 1'b0;
                sh_r = {a[3:0], a[7:4]};
            end
            default:
            begin
                sh_c = a[0];
                sh_r = {1'b0, a[7:1]};
            end
        endcase

        res = a16;
        fl  = fin;
        wb  = 1'b1;

        unique case (op_raw)
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC:
            begin
                res = {8'd0, sum9[7:0]};
                fl  = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
            begin
                res = {8'd0, diff9[7:0]};
                fl  = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
                wb  = (cpualu_pkg::op_t'(op_raw) != cpualu_pkg::OP_CP);
            end
            cpualu_pkg::OP_AND:
            begin
                res = {8'd0, a & b};
                fl  = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            cpualu_pkg::OP_XOR:
            begin
                res = {8'd0, a ^ b};
                fl  = {((a ^ b) == 8'd0), 3'b000};
            end
            cpualu_pkg::OP_OR:
            begin
                res = {8'd0, a | b};
                fl  = {((a | b) == 8'd0), 3'b000};
            end
            cpualu_pkg::OP_INC8:
            begin
                res = {8'd0, inc8};
                fl  = {(inc8 == 8'd0), 1'b0, (inc8[3:0] == 4'h0), cin};
            end
            cpualu_pkg::OP_DEC8:
            begin
                res = {8'd0, dec8};
                fl  = {(dec8 == 8'd0), 1'b1, (dec8[3:0] == 4'hF), cin};
            end
            cpualu_pkg::OP_DAA:
            begin
                res = {8'd0, daa_r};
                fl  = {(daa_r == 8'd0), fin[cpualu_pkg::FLAG_N], 1'b0, daa_c};
            end
            cpualu_pkg::OP_CPL:
            begin
                res = {8'd0, ~a};
                fl  = {fin[cpualu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
            end
            cpualu_pkg::OP_SCF:
            begin
                res = {8'd0, a};
                wb  = 1'b0;
                fl  = {fin[cpualu_pkg::FLAG_Z], 3'b001};
            end
            cpualu_pkg::OP_CCF:
            begin
                res = {8'd0, a};
                wb  = 1'b0;
                fl  = {fin[cpualu_pkg::FLAG_Z], 2'b00, ~cin};
            end
            cpualu_pkg::OP_RLCA:
            begin
                res = {8'd0, a[6:0], a[7]};
                fl  = {3'b000, a[7]};
            end
            cpualu_pkg::OP_RRCA:
            begin
                res = {8'd0, a[0], a[7:1]};
                fl  = {3'b000, a[0]};
            end
            cpualu_pkg::OP_RLA:
            begin
                res = {8'd0, a[6:0], cin};
                fl  = {3'b000, a[7]};
            end
            cpualu_pkg::OP_RRA:
            begin
                res = {8'd0, cin, a[7:1]};
                fl  = {3'b000, a[0]};
            end
            cpualu_pkg::OP_PREFIX:
            begin
                unique case (cpualu_pkg::pgrp_t'(pgrp))
                    cpualu_pkg::GRP_BIT:
                    begin
                        res = {8'd0, a};
                        wb  = 1'b0;
                        fl  = {~a[psel], 1'b0, 1'b1, cin};
                    end
                    cpualu_pkg::GRP_RES:
                    begin
                        res = {8'd0, a & ~pmask};
                    end
                    cpualu_pkg::GRP_SET:
                    begin
                        res = {8'd0, a | pmask};
                    end
                    default:
                    begin
                        res = {8'd0, sh_r};
                        fl  = {(sh_r == 8'd0), 2'b00, sh_c};
                    end
                endcase
            end
            cpualu_pkg::OP_ADD16:
            begin
                res = sum17[15:0];
                fl  = {fin[cpualu_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            cpualu_pkg::OP_ADD_SP:
            begin
                // H and C come from the unsigned low-byte add.
                res = sp_sum;
                fl  = {2'b00, sp_h5[4], sp_c9[8]};
            end
            cpualu_pkg::OP_INC16:
            begin
                res = a16 + 16'd1;
            end
            cpualu_pkg::OP_DEC16:
            begin
                res = a16 - 16'd1;
            end
            default:
            begin
                wb = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/cpu_alu_with_flags_tb.sv
`default_nettype none

module cpu_alu_with_flags_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  pre;
        logic [3:0]  fl;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
        logic        wb;
    } alu_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [cpualu_pkg::IN_BYTES*8-1:0]   s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [cpualu_pkg::OUT_BYTES*8-1:0]  m_tdata;

    alu_req_t pending_ops[$];
    alu_rsp_t predicted_outs[$];

    logic in_fire = 1'b0;
    int   accepted_total = 0;
    int   total_items = 0;
    int   results_seen = 0;
    int   errors = 0;
    int   idle_cycles = 0;

    int   burst_left = 8;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   phase_left = 0;
    int   stall_kind = 0;

    cpu_alu_with_flags dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [3:0] flag_word(logic z, logic n, logic h, logic c);
        logic [3:0] f;
        f = '0;
        f[cpualu_pkg::FLAG_Z] = z;
        f[cpualu_pkg::FLAG_N] = n;
        f[cpualu_pkg::FLAG_H] = h;
        f[cpualu_pkg::FLAG_C] = c;
        return f;
    endfunction

    function automatic alu_rsp_t alu_predict(alu_req_t it);
        alu_rsp_t   o;
        logic [7:0] a8, b8, r8, adj;
        logic [8:0] s9;
        logic [4:0] s5;
        logic [16:0] s17;
        logic [12:0] s13;
        logic       cin, t, c;
        logic [2:0] sel;
        a8  = it.a[7:0];
        b8  = it.b[7:0];
        cin = it.fl[cpualu_pkg::FLAG_C];
        sel = it.pre[5:3];
        o.result = it.a;
        o.flags  = it.fl;
        o.wb     = 1'b1;
        case (it.op)
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC:
            begin
                t = (it.op == cpualu_pkg::OP_ADC) ? cin : 1'b0;
                s9 = {1'b0, a8} + {1'b0, b8} + {8'd0, t};
                s5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, t};
                o.result = {8'h00, s9[7:0]};
                o.flags = flag_word(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
            begin
                t = (it.op == cpualu_pkg::OP_SBC) ? cin : 1'b0;
                // A negative 9-bit difference leaves the borrow in bit 8.
                s9 = {1'b0, a8} - {1'b0, b8} - {8'd0, t};
                s5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, t};
                o.result = {8'h00, s9[7:0]};
                o.flags = flag_word(s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]);
                if (it.op == cpualu_pkg::OP_CP)
                    o.wb = 1'b0;
            end
            cpualu_pkg::OP_AND:
            begin
                r8 = a8 & b8;
                o.result = {8'h00, r8};
                o.flags = flag_word(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            cpualu_pkg::OP_XOR, cpualu_pkg::OP_OR:
            begin
                r8 = (it.op == cpualu_pkg::OP_XOR) ? (a8 ^ b8) : (a8 | b8);
                o.result = {8'h00, r8};
                o.flags = flag_word(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            cpualu_pkg::OP_INC8:
            begin
                r8 = a8 + 8'd1;
                o.result = {8'h00, r8};
                o.flags = flag_word(r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cin);
            end
            cpualu_pkg::OP_DEC8:
            begin
                r8 = a8 - 8'd1;
                o.result = {8'h00, r8};
                o.flags = flag_word(r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cin);
            end
            cpualu_pkg::OP_DAA:
            begin
                adj = 8'h00;
                t = 1'b0;
                if (it.fl[cpualu_pkg::FLAG_H] ||
                    (!it.fl[cpualu_pkg::FLAG_N] && a8[3:0] > cpualu_pkg::DAA_NIB_MAX))
                    adj = cpualu_pkg::DAA_ADJ_LO;
                if (cin || (!it.fl[cpualu_pkg::FLAG_N] && a8 > cpualu_pkg::DAA_LIMIT))
                begin
                    adj = adj | cpualu_pkg::DAA_ADJ_HI;
                    t = 1'b1;
                end
                r8 = it.fl[cpualu_pkg::FLAG_N] ? (a8 - adj) : (a8 + adj);
                o.result = {8'h00, r8};
                o.flags = flag_word(r8 == 8'h00, it.fl[cpualu_pkg::FLAG_N], 1'b0, t);
            end
            cpualu_pkg::OP_CPL:
            begin
                o.result = {8'h00, ~a8};
                o.flags = flag_word(it.fl[cpualu_pkg::FLAG_Z], 1'b1, 1'b1, cin);
            end
            cpualu_pkg::OP_SCF, cpualu_pkg::OP_CCF:
            begin
                o.result = {8'h00, a8};
                o.wb = 1'b0;
                o.flags = flag_word(it.fl[cpualu_pkg::FLAG_Z], 1'b0, 1'b0,
                                    (it.op == cpualu_pkg::OP_SCF) ? 1'b1 : ~cin);
            end
            cpualu_pkg::OP_RLCA:
            begin
                o.result = {8'h00, a8[6:0], a8[7]};
                o.flags = flag_word(1'b0, 1'b0, 1'b0, a8[7]);
            end
            cpualu_pkg::OP_RRCA:
            begin
                o.result = {8'h00, a8[0], a8[7:1]};
                o.flags = flag_word(1'b0, 1'b0, 1'b0, a8[0]);
            end
            cpualu_pkg::OP_RLA:
            begin
                o.result = {8'h00, a8[6:0], cin};
                o.flags = flag_word(1'b0, 1'b0, 1'b0, a8[7]);
            end
            cpualu_pkg::OP_RRA:
            begin
                o.result = {8'h00, cin, a8[7:1]};
                o.flags = flag_word(1'b0, 1'b0, 1'b0, a8[0]);
            end
            cpualu_pkg::OP_PREFIX:
            begin
                case (it.pre[7:6])
                    cpualu_pkg::GRP_BIT:
                    begin
                        o.result = {8'h00, a8};
                        o.wb = 1'b0;
                        o.flags = flag_word(~a8[sel], 1'b0, 1'b1, cin);
                    end
                    cpualu_pkg::GRP_RES:
                        o.result = {8'h00, a8 & ~(8'h01 << sel)};
                    cpualu_pkg::GRP_SET:
                        o.result = {8'h00, a8 | (8'h01 << sel)};
                    default:
                    begin
                        case (sel)
                            cpualu_pkg::SH_RLC:  begin r8 = {a8[6:0], a8[7]}; c = a8[7]; end
                            cpualu_pkg::SH_RRC:  begin r8 = {a8[0], a8[7:1]}; c = a8[0]; end
                            cpualu_pkg::SH_RL:   begin r8 = {a8[6:0], cin};   c = a8[7]; end
                            cpualu_pkg::SH_RR:   begin r8 = {cin, a8[7:1]};   c = a8[0]; end
                            cpualu_pkg::SH_SLA:  begin r8 = {a8[6:0], 1'b0};  c = a8[7]; end
                            cpualu_pkg::SH_SRA:  begin r8 = {a8[7], a8[7:1]}; c = a8[0]; end
                            cpualu_pkg::SH_SWAP: begin r8 = {a8[3:0], a8[7:4]}; c = 1'b0; end
                            default:             begin r8 = {1'b0, a8[7:1]};  c = a8[0]; end
                        endcase
                        o.result = {8'h00, r8};
                        o.flags = flag_word(r8 == 8'h00, 1'b0, 1'b0, c);
                    end
                endcase
            end
            cpualu_pkg::OP_ADD16:
            begin
                s17 = {1'b0, it.a} + {1'b0, it.b};
                s13 = {1'b0, it.a[11:0]} + {1'b0, it.b[11:0]};
                o.result = s17[15:0];
                o.flags = flag_word(it.fl[cpualu_pkg::FLAG_Z], 1'b0, s13[12], s17[16]);
            end
            cpualu_pkg::OP_ADD_SP:
            begin
                // H and C come from the unsigned add of the low bytes; Z and N are cleared.
                s9 = {1'b0, a8} + {1'b0, b8};
                s5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
                o.result = it.a + {{8{b8[7]}}, b8};
                o.flags = flag_word(1'b0, 1'b0, s5[4], s9[8]);
            end
            cpualu_pkg::OP_INC16:
                o.result = it.a + 16'd1;
            cpualu_pkg::OP_DEC16:
                o.result = it.a - 16'd1;
            default:
                o.wb = 1'b0;
        endcase
        return o;
    endfunction

    task automatic queue_op(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                            logic [7:0] pre, logic [3:0] fl);
        alu_req_t it;
        it.op = op;
        it.a = a;
        it.b = b;
        it.pre = pre;
        it.fl = fl;
        pending_ops.push_back(it);
    endtask

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom());
        case ($urandom_range(0, 9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v[7:0] = 8'hFF;
            3: v[7:0] = 8'h00;
            4: v[7:0] = 8'h80;
            5: v[11:0] = 12'hFFF;
            6: v[7:0] = 8'h99;
            default: ;
        endcase
        return v;
    endfunction

    // Sender: bursts of items separated by random gaps.
    always @(negedge clk)
    begin : sender
        alu_req_t it;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                it = pending_ops.pop_front();
                s_tdata <= {7'd0, it.fl, it.pre, it.b, it.a, it.op};
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left = burst_left - 1;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off that backs up the input.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_kind = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 96);
            end
            phase_left = phase_left - 1;
            case (stall_kind)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : input_side
        alu_req_t req;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.op  = s_tdata[4:0];
            req.a   = s_tdata[20:5];
            req.b   = s_tdata[36:21];
            req.pre = s_tdata[44:37];
            req.fl  = s_tdata[48:45];
            predicted_outs.push_back(alu_predict(req));
            accepted_total = accepted_total + 1;
        end
    end

    always @(posedge clk)
    begin : result_check
        alu_rsp_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.result = m_tdata[15:0];
            got.flags  = m_tdata[19:16];
            got.wb     = m_tdata[20];
            results_seen = results_seen + 1;
            if (predicted_outs.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: result item with none expected: result %h flags %h wb %b",
                         $time, got.result, got.flags, got.wb);
            end
            else
            begin
                want = predicted_outs.pop_front();
                if (want !== got)
                begin
                    errors = errors + 1;
                    $display("%0t: mismatch: expected %h flags %h wb %b, got %h flags %h wb %b",
                             $time, want.result, want.flags, want.wb,
                             got.result, got.flags, got.wb);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        // Directed items: carries, borrows, zero results and flag corner cases.
        queue_op(cpualu_pkg::OP_ADD,    16'h00FF, 16'h0001, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_ADC,    16'h000F, 16'h0000, 8'h00, 4'h1);
        queue_op(cpualu_pkg::OP_SUB,    16'hAB55, 16'hCD55, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_SBC,    16'h0000, 16'h0000, 8'h00, 4'h1);
        queue_op(cpualu_pkg::OP_SBC,    16'h0001, 16'h0000, 8'h00, 4'h1);
        queue_op(cpualu_pkg::OP_AND,    16'h00F0, 16'h000F, 8'h00, 4'hF);
        queue_op(cpualu_pkg::OP_XOR,    16'hFFFF, 16'h00FF, 8'hFF, 4'hF);
        queue_op(cpualu_pkg::OP_OR,     16'h0000, 16'h0000, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_CP,     16'h0042, 16'h0042, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_INC8,   16'h00FF, 16'h0000, 8'h00, 4'h1);
        queue_op(cpualu_pkg::OP_DEC8,   16'h0010, 16'h0000, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_DAA,    16'h009A, 16'h0000, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_DAA,    16'h0000, 16'h0000, 8'h00, 4'h7);
        queue_op(cpualu_pkg::OP_CPL,    16'h00A5, 16'h0000, 8'h00, 4'h9);
        queue_op(cpualu_pkg::OP_SCF,    16'h1234, 16'h0000, 8'h00, 4'hE);
        queue_op(cpualu_pkg::OP_CCF,    16'h00FF, 16'h0000, 8'h00, 4'h9);
        queue_op(cpualu_pkg::OP_RLCA,   16'h0080, 16'h0000, 8'h00, 4'h8);
        queue_op(cpualu_pkg::OP_RRA,    16'h0001, 16'h0000, 8'h00, 4'h1);
        queue_op(cpualu_pkg::OP_PREFIX, 16'h007F, 16'h0000,
                 {cpualu_pkg::GRP_BIT, 3'd7, 3'd0}, 4'h1);
        queue_op(cpualu_pkg::OP_PREFIX, 16'h00FF, 16'h0000,
                 {cpualu_pkg::GRP_RES, 3'd0, 3'd7}, 4'h0);
        queue_op(cpualu_pkg::OP_PREFIX, 16'h0081, 16'h0000,
                 {cpualu_pkg::GRP_SHIFT, cpualu_pkg::SH_SRA, 3'd0}, 4'h0);
        queue_op(cpualu_pkg::OP_PREFIX, 16'h00F0, 16'h0000,
                 {cpualu_pkg::GRP_SHIFT, cpualu_pkg::SH_SWAP, 3'd0}, 4'hF);
        queue_op(cpualu_pkg::OP_ADD16,  16'h0FFF, 16'h0001, 8'h00, 4'h0);
        queue_op(cpualu_pkg::OP_ADD16,  16'hFFFF, 16'hFFFF, 8'h00, 4'h8);
        queue_op(cpualu_pkg::OP_ADD_SP, 16'h000F, 16'h0081, 8'h00, 4'hF);
        queue_op(cpualu_pkg::OP_INC16,  16'hFFFF, 16'h0000, 8'h00, 4'h5);
        queue_op(cpualu_pkg::OP_DEC16,  16'h0000, 16'h0000, 8'h00, 4'hA);
        queue_op(5'd31,                 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);

        // Random items; the prefixed group gets extra weight for its many sub-cases.
        repeat (RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            queue_op((r < 5) ? 5'($urandom_range(23, 31)) :
                     (r < 30) ? cpualu_pkg::OP_PREFIX : 5'($urandom_range(0, 22)),
                     pick_operand(), pick_operand(),
                     8'($urandom()), 4'($urandom()));
        end
        total_items = pending_ops.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_total != total_items)
            @(negedge clk);
        while (predicted_outs.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> cpu_alu_with_flags.f
rtl/core/cpualu_pkg.sv
rtl/core/cpu_alu_with_flags.sv
tb/cpu_alu_with_flags_tb.sv
